// ----- hdl/ntct_pkg.sv -----
package ntct_pkg;

   localparam int CONN_ENTRIES = 64;
   localparam int AGE_BITS = 16;
   localparam int ENTRY_IDX_BITS = (CONN_ENTRIES > 1) ? $clog2(CONN_ENTRIES) : 1;
   localparam int CNT_BITS = $clog2(CONN_ENTRIES + 1);
   localparam int TCP_STATE_BITS = 4;
   localparam int ENTRY_BITS = TCP_STATE_BITS + AGE_BITS;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam int TIMEOUT_BITS = 16;
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ESTABLISHED = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TRANSITORY = 1'b1;
   localparam logic [TIMEOUT_BITS-1:0] ESTABLISHED_RESET = 16'd7440;
   localparam logic [TIMEOUT_BITS-1:0] TRANSITORY_RESET = 16'd300;

   // item kinds on the request channel
   localparam logic [1:0] KIND_OPEN = 2'd0;
   localparam logic [1:0] KIND_PACKET = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   // flag bit positions
   localparam int FLAG_FIN = 0;
   localparam int FLAG_SYN = 1;
   localparam int FLAG_RST = 2;
   localparam int FLAG_ACK = 4;

   typedef logic [1:0] op_type;
   localparam op_type OP_OPEN = 2'd0;
   localparam op_type OP_PACKET = 2'd1;
   localparam op_type OP_TICK = 2'd2;
   localparam op_type OP_NONE = 2'd3;

   typedef struct packed {
      op_type                    op;
      logic [ENTRY_IDX_BITS-1:0] idx;
      logic                      fin;
      logic                      syn;
      logic                      rst;
      logic                      ack;
      logic                      outside;
   } cmd_type;

   typedef struct packed {
      logic [TIMEOUT_BITS-1:0] established;
      logic [TIMEOUT_BITS-1:0] transitory;
   } timeout_type;

endpackage

// ----- hdl/ntct_if.sv -----
interface ntct_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [5:0] conn_index;
   logic [7:0] flag_bits;
   logic       from_outside;

   modport source (output valid, kind, conn_index, flag_bits, from_outside, input ready);
   modport sink (input valid, kind, conn_index, flag_bits, from_outside, output ready);
endinterface

interface ntct_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [3:0] conn_state;
   logic [6:0] expired_count;

   modport source (output valid, status, conn_state, expired_count, input ready);
   modport sink (input valid, status, conn_state, expired_count, output ready);
endinterface

interface ntct_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ntct_pkg::CSR_IDX_BITS-1:0] index;
   logic [ntct_pkg::TIMEOUT_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/nat_tcp_connection_tracker_unit.sv -----
// nat tcp connection tracker: a table of tcp connection entries, each with a
// valid mark, a tracking state and an idle age in seconds.
// req_bus carries one item per transaction: open, packet or one-second tick.
// rsp_bus returns exactly one result per item, in order. csr_bus writes the
// established and transitory timeouts; it is always ready, and the user must
// see that it is written only while the block is idle: the block itself does
// not enforce this. items pass a two-entry queue into the execution side, so
// the request side keeps accepting while a result waits on rsp_bus. the
// execution side takes one item at a time: a packet reads its entry from the
// entry memory and then writes it if the entry is valid, an open writes its
// entry once, and a tick sweeps the whole table, ageing one entry per cycle
// through the single memory port pair. reset clears all valid marks at once
// and restores the default timeouts; there is no clearing pass. a stalled
// rsp_bus holds the result register, then the execution side, then the
// queue, and finally req_bus ready drops.
module nat_tcp_connection_tracker_unit (
   input  logic        clock,
   input  logic        reset,
   ntct_req_if.sink    req_bus,
   ntct_rsp_if.source  rsp_bus,
   ntct_csr_if.sink    csr_bus
);

   ntct_pkg::cmd_type     push_cmd;
   ntct_pkg::cmd_type     q_head;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_empty;
   logic                  q_full;
   ntct_pkg::timeout_type timeout_ff, timeout_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      timeout_in = timeout_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            ntct_pkg::CSR_ESTABLISHED: timeout_in.established = csr_bus.data;
            ntct_pkg::CSR_TRANSITORY: timeout_in.transitory = csr_bus.data;
            default: timeout_in = timeout_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff.established <= ntct_pkg::ESTABLISHED_RESET;
         timeout_ff.transitory <= ntct_pkg::TRANSITORY_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   ntct_front u_front (
      .req_bus (req_bus),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_cmd   (push_cmd)
   );

   ntct_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   ntct_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .timeouts (timeout_ff),
      .rsp_bus  (rsp_bus)
   );

`ifndef ASSERT_OFF
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("transaction pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("execution side popped an empty queue");

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_bus.valid)
      else $error("result valid right after reset");
`endif

endmodule

// ----- hdl/ntct_front.sv -----
module ntct_front (
   ntct_req_if.sink            req_bus,
   input  logic                q_full,
   output logic                q_push,
   output ntct_pkg::cmd_type   q_cmd
);

   logic in_range;

   assign in_range = 32'(req_bus.conn_index) < ntct_pkg::CONN_ENTRIES;

   assign req_bus.ready = !q_full;
   assign q_push = req_bus.valid && !q_full;

   always_comb begin
      q_cmd.idx = ntct_pkg::ENTRY_IDX_BITS'(req_bus.conn_index);
      q_cmd.fin = req_bus.flag_bits[ntct_pkg::FLAG_FIN];
      q_cmd.syn = req_bus.flag_bits[ntct_pkg::FLAG_SYN];
      q_cmd.rst = req_bus.flag_bits[ntct_pkg::FLAG_RST];
      q_cmd.ack = req_bus.flag_bits[ntct_pkg::FLAG_ACK];
      q_cmd.outside = req_bus.from_outside;
      unique case (req_bus.kind)
         ntct_pkg::KIND_OPEN: begin
            q_cmd.op = in_range ? ntct_pkg::OP_OPEN : ntct_pkg::OP_NONE;
         end
         ntct_pkg::KIND_PACKET: begin
            q_cmd.op = in_range ? ntct_pkg::OP_PACKET : ntct_pkg::OP_NONE;
         end
         ntct_pkg::KIND_TICK: begin
            q_cmd.op = ntct_pkg::OP_TICK;
         end
         default: begin
            q_cmd.op = ntct_pkg::OP_NONE;
         end
      endcase
   end

endmodule

// ----- hdl/ntct_queue.sv -----
module ntct_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ntct_pkg::cmd_type push_cmd,
   input  logic              pop,
   output ntct_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);

   ntct_pkg::cmd_type                       slot_ff [ntct_pkg::QUEUE_DEPTH];
   logic [ntct_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ntct_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ntct_pkg::QUEUE_CNT_BITS-1:0]     count_ff, count_in;

   localparam logic [ntct_pkg::QUEUE_PTR_BITS-1:0] LAST_PTR =
      ntct_pkg::QUEUE_PTR_BITS'(ntct_pkg::QUEUE_DEPTH - 1);
   localparam logic [ntct_pkg::QUEUE_CNT_BITS-1:0] DEPTH_CNT =
      ntct_pkg::QUEUE_CNT_BITS'(ntct_pkg::QUEUE_DEPTH);

   assign empty = count_ff == '0;
   assign full = count_ff == DEPTH_CNT;
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hdl/ntct_back.sv -----
module ntct_back (
   input  logic                  clock,
   input  logic                  reset,
   input  ntct_pkg::cmd_type     q_head,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  ntct_pkg::timeout_type timeouts,
   ntct_rsp_if.source            rsp_bus
);

   localparam int IW = ntct_pkg::ENTRY_IDX_BITS;
   localparam int SW = ntct_pkg::TCP_STATE_BITS;
   localparam int AW = ntct_pkg::AGE_BITS;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SWEEP = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   localparam logic [SW-1:0] ST_CLOSED1 = 4'd0;
   localparam logic [SW-1:0] ST_SYN_SENT = 4'd1;
   localparam logic [SW-1:0] ST_SYN_RCVD = 4'd2;
   localparam logic [SW-1:0] ST_ESTAB = 4'd3;
   localparam logic [SW-1:0] ST_FIN_WAIT1 = 4'd4;
   localparam logic [SW-1:0] ST_FIN_WAIT2 = 4'd5;
   localparam logic [SW-1:0] ST_CLOSING = 4'd6;
   localparam logic [SW-1:0] ST_CLOSE_WAIT = 4'd7;
   localparam logic [SW-1:0] ST_LAST_ACK = 4'd8;
   localparam logic [SW-1:0] ST_TIME_WAIT = 4'd9;
   localparam logic [SW-1:0] ST_CLOSED2 = 4'd10;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_DROP = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   localparam logic [IW-1:0] LAST_IDX = IW'(ntct_pkg::CONN_ENTRIES - 1);

   // returns {allowed, next state}
   function automatic logic [SW:0] track(input logic [SW-1:0] st, input ntct_pkg::cmd_type c);
      logic          ok;
      logic [SW-1:0] nxt;
      logic          ins;
      ok = 1'b0;
      nxt = st;
      ins = !c.outside;
      if (c.rst) begin
         ok = 1'b1;
         nxt = ST_CLOSED2;
      end else begin
         unique case (st)
            ST_CLOSED1: begin
               if (c.syn && ins) begin ok = 1'b1; nxt = ST_SYN_SENT; end
            end
            ST_SYN_SENT: begin
               if (c.syn && c.ack && c.outside) begin ok = 1'b1; nxt = ST_ESTAB; end
               else if (c.syn && c.outside) begin ok = 1'b1; nxt = ST_SYN_RCVD; end
            end
            ST_SYN_RCVD: begin
               if (c.ack && c.outside) begin ok = 1'b1; nxt = ST_ESTAB; end
               else if (c.fin && ins) begin ok = 1'b1; nxt = ST_FIN_WAIT1; end
               else if (c.ack && ins) ok = 1'b1;
            end
            ST_ESTAB: begin
               if (c.ack) ok = 1'b1;
               else if (c.fin && ins) begin ok = 1'b1; nxt = ST_FIN_WAIT1; end
               else if (c.fin && c.outside) begin ok = 1'b1; nxt = ST_CLOSE_WAIT; end
            end
            ST_FIN_WAIT1: begin
               if (c.fin && ins) ok = 1'b1;
               else if (c.ack && c.outside) begin ok = 1'b1; nxt = ST_FIN_WAIT2; end
               else if (c.fin && c.outside) begin ok = 1'b1; nxt = ST_CLOSING; end
            end
            ST_FIN_WAIT2: begin
               if (c.fin && c.outside) begin ok = 1'b1; nxt = ST_TIME_WAIT; end
            end
            ST_CLOSING: begin
               if (c.ack && ins) ok = 1'b1;
               else if (c.ack && c.outside) begin ok = 1'b1; nxt = ST_TIME_WAIT; end
            end
            ST_CLOSE_WAIT: begin
               if (c.ack && ins) ok = 1'b1;
               else if (c.fin && ins) begin ok = 1'b1; nxt = ST_LAST_ACK; end
            end
            ST_LAST_ACK: begin
               if ((c.fin && ins) || (c.ack && c.outside)) ok = 1'b1;
            end
            ST_TIME_WAIT: begin
               if (c.ack && ins) ok = 1'b1;
            end
            default: begin
               ok = 1'b0;
            end
         endcase
      end
      return {ok, nxt};
   endfunction

   logic [1:0]                       fsm_ff, fsm_in;
   ntct_pkg::cmd_type                cmd_ff, cmd_in;
   logic [IW-1:0]                    sweep_ff, sweep_in;
   logic [ntct_pkg::CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [ntct_pkg::CONN_ENTRIES-1:0] valid_ff, valid_in;

   logic [ntct_pkg::ENTRY_BITS-1:0]  mem [ntct_pkg::CONN_ENTRIES];
   logic [ntct_pkg::ENTRY_BITS-1:0]  rd_data_ff;
   logic [IW-1:0]                    rd_addr;
   logic [IW-1:0]                    wr_addr;
   logic [ntct_pkg::ENTRY_BITS-1:0]  wr_data;
   logic                             wr_en;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [1:0]                       status_ff, status_in;
   logic [SW-1:0]                    cstate_ff, cstate_in;
   logic [6:0]                       expired_ff, expired_in;
   logic                             load;
   logic                             out_free;

   logic [SW-1:0]                    cur_state;
   logic [AW-1:0]                    cur_age;
   logic [AW-1:0]                    age_new;
   logic                             gone;
   logic [SW:0]                      tr;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign cur_state = rd_data_ff[ntct_pkg::ENTRY_BITS-1 -: SW];
   assign cur_age = rd_data_ff[AW-1:0];
   assign age_new = (&cur_age) ? cur_age : cur_age + 1'b1;
   assign tr = track(cur_state, cmd_ff);

   always_comb begin
      if (cur_state == ST_ESTAB) begin
         gone = 32'(age_new) >= 32'(timeouts.established);
      end else begin
         gone = (32'(age_new) >= 32'(timeouts.transitory)) || (cur_state == ST_CLOSED2);
      end
   end

   always_comb begin
      fsm_in = fsm_ff;
      cmd_in = cmd_ff;
      sweep_in = sweep_ff;
      cnt_in = cnt_ff;
      valid_in = valid_ff;
      q_pop = 1'b0;
      rd_addr = cmd_ff.idx;
      wr_addr = cmd_ff.idx;
      wr_data = '0;
      wr_en = 1'b0;
      load = 1'b0;
      status_in = STATUS_OK;
      cstate_in = ST_CLOSED1;
      expired_in = '0;
      unique case (fsm_ff)
         S_IDLE: begin
            if (!q_empty) begin
               unique case (q_head.op)
                  ntct_pkg::OP_PACKET: begin
                     q_pop = 1'b1;
                     cmd_in = q_head;
                     rd_addr = q_head.idx;
                     fsm_in = S_EXEC;
                  end
                  ntct_pkg::OP_TICK: begin
                     q_pop = 1'b1;
                     rd_addr = '0;
                     sweep_in = '0;
                     cnt_in = '0;
                     fsm_in = S_SWEEP;
                  end
                  ntct_pkg::OP_OPEN: begin
                     if (out_free) begin
                        q_pop = 1'b1;
                        wr_en = 1'b1;
                        wr_addr = q_head.idx;
                        wr_data = {ST_CLOSED1, AW'(0)};
                        valid_in[q_head.idx] = 1'b1;
                        load = 1'b1;
                     end
                  end
                  default: begin
                     if (out_free) begin
                        q_pop = 1'b1;
                        load = 1'b1;
                        status_in = STATUS_INVALID;
                     end
                  end
               endcase
            end
         end
         S_EXEC: begin
            // read data holds while the result slot is busy
            if (out_free) begin
               load = 1'b1;
               fsm_in = S_IDLE;
               if (valid_ff[cmd_ff.idx]) begin
                  wr_en = 1'b1;
                  wr_data = {tr[SW-1:0], AW'(0)};
                  status_in = tr[SW] ? STATUS_OK : STATUS_DROP;
                  cstate_in = tr[SW-1:0];
               end else begin
                  status_in = STATUS_INVALID;
               end
            end
         end
         S_SWEEP: begin
            // write back or expire entry sweep_ff while fetching the next one
            rd_addr = sweep_ff + 1'b1;
            wr_addr = sweep_ff;
            if (valid_ff[sweep_ff]) begin
               if (gone) begin
                  valid_in[sweep_ff] = 1'b0;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  wr_en = 1'b1;
                  wr_data = {cur_state, age_new};
               end
            end
            if (sweep_ff == LAST_IDX) begin
               fsm_in = S_DONE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               load = 1'b1;
               expired_in = 7'(cnt_ff);
               fsm_in = S_IDLE;
            end
         end
         default: begin
            fsm_in = S_IDLE;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= S_IDLE;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff <= fsm_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      sweep_ff <= sweep_in;
      cnt_ff <= cnt_in;
      if (load) begin
         status_ff <= status_in;
         cstate_ff <= cstate_in;
         expired_ff <= expired_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.status = status_ff;
   assign rsp_bus.conn_state = cstate_ff;
   assign rsp_bus.expired_count = expired_ff;

endmodule

// ----- tb/tb_nat_tcp_connection_tracker_unit.sv -----
module tb_nat_tcp_connection_tracker_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_ITEMS = 80;
   localparam int LONG_HOLD_AT = 150;
   localparam int LONG_HOLD_CYCLES = 400;

   localparam logic [7:0] F_FIN = 8'(1 << ntct_pkg::FLAG_FIN);
   localparam logic [7:0] F_SYN = 8'(1 << ntct_pkg::FLAG_SYN);
   localparam logic [7:0] F_RST = 8'(1 << ntct_pkg::FLAG_RST);
   localparam logic [7:0] F_ACK = 8'(1 << ntct_pkg::FLAG_ACK);
   // flag bits the tracker never looks at
   localparam logic [7:0] NOISE_MASK = 8'hE8;

   typedef enum logic [3:0] {
      TS_CLOSED1, TS_SYN_SENT, TS_SYN_RCVD, TS_ESTAB, TS_FIN_WAIT1, TS_FIN_WAIT2,
      TS_CLOSING, TS_CLOSE_WAIT, TS_LAST_ACK, TS_TIME_WAIT, TS_CLOSED2
   } tcp_state_type;

   typedef enum logic [1:0] {
      RSP_ACCEPTED, RSP_DROP, RSP_INVALID
   } rsp_status_type;

   typedef struct packed {
      rsp_status_type status;
      tcp_state_type  conn_state;
      logic [6:0]     expired;
   } conn_result_type;

   class conn_mirror_type;
      bit                                live [ntct_pkg::CONN_ENTRIES];
      tcp_state_type                     phase [ntct_pkg::CONN_ENTRIES];
      logic [ntct_pkg::AGE_BITS-1:0]     idle_age [ntct_pkg::CONN_ENTRIES];
      logic [ntct_pkg::TIMEOUT_BITS-1:0] estab_limit;
      logic [ntct_pkg::TIMEOUT_BITS-1:0] trans_limit;
      conn_result_type                   awaited [$];
      int                                failures;

      function void clear();
         estab_limit = ntct_pkg::ESTABLISHED_RESET;
         trans_limit = ntct_pkg::TRANSITORY_RESET;
         failures = 0;
         for (int i = 0; i < ntct_pkg::CONN_ENTRIES; i++) begin
            live[i] = 1'b0;
            phase[i] = TS_CLOSED1;
            idle_age[i] = '0;
         end
      endfunction

      function void write_timeout(logic [ntct_pkg::CSR_IDX_BITS-1:0] index,
                                  logic [ntct_pkg::TIMEOUT_BITS-1:0] value);
         if (index == ntct_pkg::CSR_ESTABLISHED) begin
            estab_limit = value;
         end else begin
            trans_limit = value;
         end
      endfunction

      // next tracking state for one packet; allowed low means drop
      function tcp_state_type advance(tcp_state_type st, logic [7:0] flags, logic outside,
                                      output bit allowed);
         bit fin;
         bit syn;
         bit ack;
         bit inward;
         tcp_state_type nxt;
         fin = flags[ntct_pkg::FLAG_FIN];
         syn = flags[ntct_pkg::FLAG_SYN];
         ack = flags[ntct_pkg::FLAG_ACK];
         inward = !outside;
         nxt = st;
         allowed = 1'b0;
         if (flags[ntct_pkg::FLAG_RST]) begin
            nxt = TS_CLOSED2;
            allowed = 1'b1;
         end else begin
            case (st)
               TS_CLOSED1: begin
                  if (syn && inward) begin nxt = TS_SYN_SENT; allowed = 1'b1; end
               end
               TS_SYN_SENT: begin
                  if (syn && ack && outside) begin nxt = TS_ESTAB; allowed = 1'b1; end
                  else if (syn && outside) begin nxt = TS_SYN_RCVD; allowed = 1'b1; end
               end
               TS_SYN_RCVD: begin
                  if (ack && outside) begin nxt = TS_ESTAB; allowed = 1'b1; end
                  else if (fin && inward) begin nxt = TS_FIN_WAIT1; allowed = 1'b1; end
                  else if (ack && inward) allowed = 1'b1;
               end
               TS_ESTAB: begin
                  if (ack) allowed = 1'b1;
                  else if (fin && inward) begin nxt = TS_FIN_WAIT1; allowed = 1'b1; end
                  else if (fin && outside) begin nxt = TS_CLOSE_WAIT; allowed = 1'b1; end
               end
               TS_FIN_WAIT1: begin
                  if (fin && inward) allowed = 1'b1;
                  else if (ack && outside) begin nxt = TS_FIN_WAIT2; allowed = 1'b1; end
                  else if (fin && outside) begin nxt = TS_CLOSING; allowed = 1'b1; end
               end
               TS_FIN_WAIT2: begin
                  if (fin && outside) begin nxt = TS_TIME_WAIT; allowed = 1'b1; end
               end
               TS_CLOSING: begin
                  if (ack && inward) allowed = 1'b1;
                  else if (ack && outside) begin nxt = TS_TIME_WAIT; allowed = 1'b1; end
               end
               TS_CLOSE_WAIT: begin
                  if (ack && inward) allowed = 1'b1;
                  else if (fin && inward) begin nxt = TS_LAST_ACK; allowed = 1'b1; end
               end
               TS_LAST_ACK: begin
                  if ((fin && inward) || (ack && outside)) allowed = 1'b1;
               end
               TS_TIME_WAIT: begin
                  if (ack && inward) allowed = 1'b1;
               end
               default: ;
            endcase
         end
         return nxt;
      endfunction

      function void note_item(logic [1:0] kind, logic [5:0] idx, logic [7:0] flags,
                              logic outside);
         conn_result_type res;
         bit ok;
         bit gone;
         int i;
         res.status = RSP_ACCEPTED;
         res.conn_state = TS_CLOSED1;
         res.expired = '0;
         case (kind)
            ntct_pkg::KIND_OPEN: begin
               if (int'(idx) < ntct_pkg::CONN_ENTRIES) begin
                  live[idx] = 1'b1;
                  phase[idx] = TS_CLOSED1;
                  idle_age[idx] = '0;
               end else begin
                  res.status = RSP_INVALID;
               end
            end
            ntct_pkg::KIND_PACKET: begin
               if (int'(idx) < ntct_pkg::CONN_ENTRIES && live[idx]) begin
                  idle_age[idx] = '0;
                  phase[idx] = advance(phase[idx], flags, outside, ok);
                  res.status = ok ? RSP_ACCEPTED : RSP_DROP;
                  res.conn_state = phase[idx];
               end else begin
                  res.status = RSP_INVALID;
               end
            end
            ntct_pkg::KIND_TICK: begin
               for (i = 0; i < ntct_pkg::CONN_ENTRIES; i++) begin
                  if (live[i]) begin
                     if (idle_age[i] != {ntct_pkg::AGE_BITS{1'b1}}) begin
                        idle_age[i] = idle_age[i] + 1'b1;
                     end
                     if (phase[i] == TS_ESTAB) begin
                        gone = idle_age[i] >= estab_limit;
                     end else begin
                        gone = idle_age[i] >= trans_limit || phase[i] == TS_CLOSED2;
                     end
                     if (gone) begin
                        live[i] = 1'b0;
                        phase[i] = TS_CLOSED1;
                        idle_age[i] = '0;
                        res.expired = res.expired + 1'b1;
                     end
                  end
               end
            end
            default: res.status = RSP_INVALID;
         endcase
         awaited.push_back(res);
      endfunction

      function void check_result(logic [1:0] status, logic [3:0] conn_state,
                                 logic [6:0] expired_count);
         conn_result_type want;
         if (awaited.size() == 0) begin
            $error("unexpected result: status %0d conn_state %0d expired_count %0d",
                   status, conn_state, expired_count);
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            failures++;
         end
         if (conn_state !== want.conn_state) begin
            $error("conn_state: expected %0d, actual %0d", want.conn_state, conn_state);
            failures++;
         end
         if (expired_count !== want.expired) begin
            $error("expired_count: expected %0d, actual %0d", want.expired, expired_count);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   bit   send_calm = 1'b0;

   conn_mirror_type mirror;

   ntct_req_if req_bus ();
   ntct_rsp_if rsp_bus ();
   ntct_csr_if csr_bus ();

   nat_tcp_connection_tracker_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic push_item(logic [1:0] kind, logic [5:0] idx, logic [7:0] flags,
                            logic outside);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 8);
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind <= kind;
      req_bus.conn_index <= idx;
      req_bus.flag_bits <= flags;
      req_bus.from_outside <= outside;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      mirror.note_item(kind, idx, flags, outside);
   endtask

   task automatic pkt(logic [5:0] idx, logic [7:0] flags, logic outside);
      push_item(ntct_pkg::KIND_PACKET, idx, flags, outside);
   endtask

   // stop offering and wait until every outstanding result is back
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (mirror.awaited.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [ntct_pkg::CSR_IDX_BITS-1:0] index,
                            logic [ntct_pkg::TIMEOUT_BITS-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      mirror.write_timeout(index, value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // flags that move a connection along its normal handshake or teardown
   task automatic guided_packet(tcp_state_type st, output logic [7:0] flags,
                                output logic outside);
      int unsigned pick;
      pick = $urandom_range(0, 2);
      outside = 1'($urandom_range(0, 1));
      flags = F_ACK;
      case (st)
         TS_CLOSED1: begin flags = F_SYN; outside = 1'b0; end
         TS_SYN_SENT: begin
            flags = (pick == 0) ? F_SYN : (F_SYN | F_ACK);
            outside = 1'b1;
         end
         TS_SYN_RCVD: begin
            flags = (pick == 1) ? F_FIN : F_ACK;
            outside = (pick == 0);
         end
         TS_ESTAB: begin
            if (pick != 0) begin flags = F_FIN; outside = (pick == 2); end
         end
         TS_FIN_WAIT1: begin
            flags = (pick == 1) ? F_ACK : F_FIN;
            outside = (pick != 0);
         end
         TS_FIN_WAIT2: begin flags = F_FIN; outside = 1'b1; end
         TS_CLOSE_WAIT: begin
            flags = (pick == 0) ? F_ACK : F_FIN;
            outside = 1'b0;
         end
         TS_LAST_ACK: begin
            flags = (pick == 0) ? F_FIN : F_ACK;
            outside = (pick != 0);
         end
         TS_TIME_WAIT: outside = 1'b0;
         default: ;
      endcase
   endtask

   task automatic random_item(output bit counted);
      logic [1:0]  kind;
      logic [5:0]  idx;
      logic [7:0]  flags;
      logic        outside;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      // mostly a handful of entries so connections get deep into their life
      idx = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
      flags = 8'($urandom_range(0, 255));
      outside = 1'($urandom_range(0, 1));
      if (roll < 8) begin
         kind = ntct_pkg::KIND_OPEN;
      end else if (roll < 18) begin
         kind = ntct_pkg::KIND_TICK;
      end else if (roll < 21) begin
         kind = ntct_pkg::OP_NONE;
      end else begin
         kind = ntct_pkg::KIND_PACKET;
         if (roll < 80) begin
            if (!mirror.live[idx] && $urandom_range(0, 1) == 1) begin
               kind = ntct_pkg::KIND_OPEN;
            end else begin
               guided_packet(mirror.phase[idx], flags, outside);
               if ($urandom_range(0, 1) == 1) flags = flags | (8'($urandom) & NOISE_MASK);
               if ($urandom_range(0, 19) == 0) flags = flags | F_RST;
            end
         end
      end
      push_item(kind, idx, flags, outside);
      counted = (kind != ntct_pkg::OP_NONE);
   endtask

   initial begin : rsp_side
      int unsigned hold;
      int unsigned seen;
      bit          calm;
      rsp_bus.ready = 1'b0;
      seen = 0;
      calm = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(0, 39) == 0) calm = !calm;
         hold = calm ? 0 : $urandom_range(0, 8);
         // one long back-pressure stretch so the block fills and stalls req_bus
         if (seen == LONG_HOLD_AT) hold = LONG_HOLD_CYCLES;
         @(negedge clock);
         if (hold != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         mirror.check_result(rsp_bus.status, rsp_bus.conn_state, rsp_bus.expired_count);
         seen++;
      end
   end

   initial begin : req_side
      logic [ntct_pkg::TIMEOUT_BITS-1:0] est;
      logic [ntct_pkg::TIMEOUT_BITS-1:0] trn;
      int  done;
      bit  counted;
      mirror = new;
      mirror.clear();
      req_bus.valid = 1'b0;
      req_bus.kind = ntct_pkg::KIND_OPEN;
      req_bus.conn_index = '0;
      req_bus.flag_bits = '0;
      req_bus.from_outside = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = ntct_pkg::CSR_ESTABLISHED;
      csr_bus.data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // invalid entry, unknown kind, then a full active close on entry 0
      pkt(6'd5, F_ACK, 1'b0);
      push_item(ntct_pkg::OP_NONE, 6'h3F, 8'hFF, 1'b1);
      push_item(ntct_pkg::KIND_OPEN, 6'd0, 8'h00, 1'b0);
      push_item(ntct_pkg::KIND_OPEN, 6'h3F, 8'hFF, 1'b1);
      pkt(6'd0, F_SYN, 1'b0);
      pkt(6'd0, F_SYN | F_ACK, 1'b1);
      pkt(6'd0, F_ACK, 1'b0);
      pkt(6'd0, F_FIN, 1'b0);
      pkt(6'd0, F_ACK, 1'b1);
      pkt(6'd0, F_FIN, 1'b1);
      pkt(6'd0, F_ACK, 1'b0);
      pkt(6'd0, F_SYN, 1'b1);
      // reopen of a live entry, passive close, then reset to closed2
      push_item(ntct_pkg::KIND_OPEN, 6'h3F, 8'h00, 1'b0);
      pkt(6'h3F, F_SYN, 1'b0);
      pkt(6'h3F, F_SYN, 1'b1);
      pkt(6'h3F, F_ACK, 1'b1);
      pkt(6'h3F, F_FIN, 1'b1);
      pkt(6'h3F, F_FIN, 1'b0);
      pkt(6'h3F, F_ACK, 1'b1);
      pkt(6'h3F, 8'hFF, 1'b1);
      push_item(ntct_pkg::KIND_TICK, 6'd0, 8'h00, 1'b0);
      pkt(6'h3F, F_ACK, 1'b0);
      // simultaneous close through closing
      push_item(ntct_pkg::KIND_OPEN, 6'd2, 8'h00, 1'b0);
      pkt(6'd2, F_SYN, 1'b0);
      pkt(6'd2, F_SYN, 1'b1);
      pkt(6'd2, F_FIN, 1'b0);
      pkt(6'd2, F_FIN, 1'b1);
      pkt(6'd2, F_ACK, 1'b1);
      pkt(6'd2, NOISE_MASK, 1'b0);
      settle();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin est = 16'd3; trn = 16'd2; end
            1: begin est = 16'hFFFF; trn = 16'hFFFF; end
            2: begin est = 16'd1; trn = 16'd1; end
            3: begin est = 16'd0; trn = 16'd0; end
            4: begin
               est = 16'($urandom_range(1, 20));
               trn = 16'($urandom_range(1, 20));
            end
            default: begin
               est = ntct_pkg::ESTABLISHED_RESET;
               trn = ntct_pkg::TRANSITORY_RESET;
            end
         endcase
         write_csr(ntct_pkg::CSR_ESTABLISHED, est);
         write_csr(ntct_pkg::CSR_TRANSITORY, trn);
         done = 0;
         while (done < PHASE_ITEMS) begin
            random_item(counted);
            if (counted) done++;
         end
         settle();
      end

      repeat (ntct_pkg::CONN_ENTRIES + 8) @(posedge clock);
      if (mirror.failures == 0 && mirror.awaited.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/ntct_pkg.sv
hdl/ntct_if.sv
hdl/ntct_front.sv
hdl/ntct_queue.sv
hdl/ntct_back.sv
hdl/nat_tcp_connection_tracker_unit.sv
tb/tb_nat_tcp_connection_tracker_unit.sv
